@@ rtl/ltdc_pkg.sv @@
// ltdc_pkg: shared types and constants for the lock table with deadlock check
// used by every module under rtl/ except ltdc_ram, no dependencies of its own
package ltdc_pkg;

  localparam int unsigned TXNS_DEF = 16;
  localparam int unsigned RES_DEF  = 64;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned ID_W   = 4;
  localparam int unsigned RES_W  = 6;
  localparam int unsigned ST_W   = 3;

  typedef enum logic [MODE_W-1:0] {
    MD_BEGIN  = 3'd0,
    MD_SHARED = 3'd1,
    MD_EXCL   = 3'd2,
    MD_COMMIT = 3'd3,
    MD_ABORT  = 3'd4
  } mode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_WAIT     = 3'd1,
    ST_DEADLOCK = 3'd2,
    ST_INACTIVE = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_NOSLOT   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_GROWING   = 2'd1,
    PH_COMMITTED = 2'd2,
    PH_ABORTED   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    K_BEGIN,
    K_SHARED,
    K_EXCL,
    K_COMMIT,
    K_ABORT,
    K_BAD
  } kind_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LREAD,
    S_REACH,
    S_REL
  } back_state_e;

  typedef struct packed {
    kind_e            kind;
    logic [ID_W-1:0]  txn;
    logic [RES_W-1:0] res;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

@@ rtl/ltdc_ram.sv @@
// ltdc_ram: generic single write port, single read port ram with registered read
// no dependencies
module ltdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ltdc_front.sv @@
// ltdc_front: request decode, resource wrap and two-entry command queue
// depends on ltdc_pkg
module ltdc_front import ltdc_pkg::*; #(
  parameter int unsigned RESOURCES = RES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [ID_W-1:0]   txn_id_i,
  input  logic [RES_W-1:0]  resource_i,
  output logic              busy_o,
  output q_head_t           head_o,
  input  logic              pop_i
);

  localparam int unsigned NRES_IN = 1 << RES_W;

  logic [RES_W-1:0] wrap_tbl [NRES_IN];
  cmd_t             cmd_in;
  cmd_t             mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push;

  // resource index wraps modulo the table depth, worked out per input code
  for (genvar v = 0; v < NRES_IN; v++) begin : g_wrap
    assign wrap_tbl[v] = RES_W'(v % RESOURCES);
  end

  always_comb begin
    cmd_in.txn = txn_id_i;
    cmd_in.res = wrap_tbl[resource_i];
    unique case (mode_i)
      MD_BEGIN:  cmd_in.kind = K_BEGIN;
      MD_SHARED: cmd_in.kind = K_SHARED;
      MD_EXCL:   cmd_in.kind = K_EXCL;
      MD_COMMIT: cmd_in.kind = K_COMMIT;
      MD_ABORT:  cmd_in.kind = K_ABORT;
      default:   cmd_in.kind = K_BAD;
    endcase
  end

  assign busy_o = cnt_q[1];
  assign push   = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = mem_q[rd_q];

endmodule

@@ rtl/ltdc_back.sv @@
// ltdc_back: lock table state, waits-for matrix, cycle check and release sweep
// depends on ltdc_pkg and ltdc_ram
module ltdc_back import ltdc_pkg::*; #(
  parameter int unsigned TXNS      = TXNS_DEF,
  parameter int unsigned RESOURCES = RES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  q_head_t         head_i,
  output logic            pop_o,
  output logic            done_o,
  output logic [ST_W-1:0] status_o,
  output logic [ID_W-1:0] new_txn_o
);

  localparam int unsigned SW  = $clog2(TXNS);
  localparam int unsigned CW  = $clog2(TXNS + 1);
  localparam int unsigned AW  = RESOURCES > 1 ? $clog2(RESOURCES) : 1;
  localparam int unsigned RCW = $clog2(RESOURCES + 1);
  localparam int unsigned EW  = 1 + SW + TXNS;

  back_state_e     state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  phase_e          phase_q [TXNS];
  phase_e          phase_d [TXNS];
  logic [TXNS-1:0] wait_q [TXNS];
  logic [TXNS-1:0] wait_d [TXNS];
  logic [CW-1:0]   id_q, id_d;
  logic [TXNS-1:0] reach_q, reach_d;
  logic [RCW-1:0]  cnt_q, cnt_d;
  logic            rd_v_q, rd_v_d;
  logic [AW-1:0]   rd_addr_q, rd_addr_d;
  status_e         rel_st_q, rel_st_d;
  logic            done_q, done_d;
  status_e         status_q, status_d;
  logic [ID_W-1:0] new_q, new_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [EW-1:0]   wdata, rdata;

  logic            ent_ov;
  logic [SW-1:0]   ent_own;
  logic [TXNS-1:0] ent_msk;
  logic [SW-1:0]   slot, hslot;
  logic [TXNS-1:0] sbit, blockers, or_rows, reach_nx;
  logic            excl, hin_range;

  ltdc_ram #(.WIDTH(EW), .DEPTH(RESOURCES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ent_ov  = rdata[EW-1];
  assign ent_own = rdata[EW-2 -: SW];
  assign ent_msk = rdata[TXNS-1:0];

  assign slot  = SW'(cmd_q.txn);
  assign sbit  = TXNS'(1) << slot;
  assign excl  = (cmd_q.kind == K_EXCL);
  assign hslot = SW'(head_i.cmd.txn);
  assign hin_range = (32'(head_i.cmd.txn) < TXNS);

  always_comb begin
    blockers = '0;
    if (ent_ov && ent_own != slot) begin
      blockers[ent_own] = 1'b1;
    end
    if (excl) begin
      blockers = blockers | (ent_msk & ~sbit);
    end
  end

  // one reachability step over the waits-for rows
  always_comb begin
    or_rows = '0;
    for (int i = 0; i < TXNS; i++) begin
      if (reach_q[i]) begin
        or_rows = or_rows | wait_q[i];
      end
    end
    reach_nx = reach_q | or_rows;
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    phase_d   = phase_q;
    wait_d    = wait_q;
    id_d      = id_q;
    reach_d   = reach_q;
    cnt_d     = cnt_q;
    rd_v_d    = 1'b0;
    rd_addr_d = rd_addr_q;
    rel_st_d  = rel_st_q;
    done_d    = 1'b0;
    status_d  = status_q;
    new_d     = '0;
    pop_o     = 1'b0;
    we        = 1'b0;
    waddr     = cnt_q[AW-1:0];
    wdata     = '0;
    raddr     = cnt_q[AW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        cnt_d = cnt_q + RCW'(1);
        if (cnt_q == RCW'(RESOURCES - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (head_i.valid) begin
          pop_o  = 1'b1;
          cmd_d  = head_i.cmd;
          done_d = 1'b1;
          status_d = ST_OK;
          case (head_i.cmd.kind)
            K_BEGIN: begin
              if (32'(id_q) >= TXNS) begin
                status_d = ST_NOSLOT;
              end else begin
                phase_d[id_q[SW-1:0]] = PH_GROWING;
                wait_d[id_q[SW-1:0]]  = '0;
                new_d = ID_W'(id_q);
                id_d  = id_q + CW'(1);
              end
            end
            K_BAD: status_d = ST_INACTIVE;
            default: begin
              if (!hin_range || phase_q[hslot] == PH_IDLE) begin
                status_d = ST_UNKNOWN;
              end else if (head_i.cmd.kind == K_SHARED || head_i.cmd.kind == K_EXCL) begin
                if (phase_q[hslot] != PH_GROWING) begin
                  status_d = ST_INACTIVE;
                end else begin
                  done_d  = 1'b0;
                  raddr   = AW'(head_i.cmd.res);
                  state_d = S_LREAD;
                end
              end else begin
                done_d = 1'b0;
                phase_d[hslot] = (head_i.cmd.kind == K_COMMIT) ? PH_COMMITTED : PH_ABORTED;
                rel_st_d = ST_OK;
                cnt_d    = '0;
                state_d  = S_REL;
              end
            end
          endcase
        end
      end

      S_LREAD: begin
        if ((ent_ov && ent_own == slot) || (!excl && ent_msk[slot])) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end else if (blockers != '0) begin
          wait_d[slot] = blockers;
          reach_d      = blockers;
          state_d      = S_REACH;
        end else begin
          we    = 1'b1;
          waddr = AW'(cmd_q.res);
          wdata = excl ? {1'b1, slot, ent_msk & ~sbit} : {ent_ov, ent_own, ent_msk | sbit};
          for (int i = 0; i < TXNS; i++) begin
            wait_d[i] = wait_q[i] & ~sbit;
          end
          wait_d[slot] = '0;
          done_d   = 1'b1;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end
      end

      S_REACH: begin
        if (reach_nx == reach_q) begin
          if (reach_q[slot]) begin
            phase_d[slot] = PH_ABORTED;
            rel_st_d = ST_DEADLOCK;
            cnt_d    = '0;
            state_d  = S_REL;
          end else begin
            done_d   = 1'b1;
            status_d = ST_WAIT;
            state_d  = S_IDLE;
          end
        end else begin
          reach_d = reach_nx;
        end
      end

      S_REL: begin
        // read one entry per cycle, write the previous one back stripped
        if (cnt_q != RCW'(RESOURCES)) begin
          raddr     = cnt_q[AW-1:0];
          rd_v_d    = 1'b1;
          rd_addr_d = cnt_q[AW-1:0];
          cnt_d     = cnt_q + RCW'(1);
        end
        if (rd_v_q) begin
          we    = 1'b1;
          waddr = rd_addr_q;
          if (ent_ov && ent_own == slot) begin
            wdata = {1'b0, SW'(0), ent_msk & ~sbit};
          end else begin
            wdata = {ent_ov, ent_own, ent_msk & ~sbit};
          end
        end
        if (cnt_q == RCW'(RESOURCES)) begin
          for (int i = 0; i < TXNS; i++) begin
            wait_d[i] = wait_q[i] & ~sbit;
          end
          wait_d[slot] = '0;
          done_d   = 1'b1;
          status_d = rel_st_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      id_q    <= '0;
      cnt_q   <= '0;
      rd_v_q  <= 1'b0;
      done_q  <= 1'b0;
      for (int i = 0; i < TXNS; i++) begin
        phase_q[i] <= PH_IDLE;
        wait_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      id_q    <= id_d;
      cnt_q   <= cnt_d;
      rd_v_q  <= rd_v_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    reach_q   <= reach_d;
    rd_addr_q <= rd_addr_d;
    rel_st_q  <= rel_st_d;
    status_q  <= status_d;
    new_q     <= new_d;
  end

  assign done_o    = done_q;
  assign status_o  = status_q;
  assign new_txn_o = new_q;

endmodule

@@ rtl/lock_table_with_deadlock_check.sv @@
// lock_table_with_deadlock_check: top level, command queue front and lock table back
// depends on ltdc_pkg, ltdc_front, ltdc_back
//
//   channel  | strobe  | hold-off | beat fields
//   request  | start_i | busy_o   | mode_i, txn_id_i, resource_i
//   result   | done_o  | none     | status_o, new_txn_o
//
// begin and rejected requests are answered from the idle state; a lock request first reads
// its lock ram entry, and a blocked lock then grows the reach set one waits-for step at a time.
// commit and abort sweep the whole lock ram; a deadlock abort sweeps it once the reach set
// has stopped growing and holds the requester.
// after reset the lock ram is cleared entry by entry; requests queue meanwhile.
// busy_o rises when the two-entry queue is full; results come as one-cycle strobes.
module lock_table_with_deadlock_check import ltdc_pkg::*; #(
  parameter int unsigned TXNS      = TXNS_DEF,
  parameter int unsigned RESOURCES = RES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [ID_W-1:0]   txn_id_i,
  input  logic [RES_W-1:0]  resource_i,
  output logic              done_o,
  output logic [ST_W-1:0]   status_o,
  output logic [ID_W-1:0]   new_txn_o
);

  q_head_t head;
  logic    pop;

  ltdc_front #(.RESOURCES(RESOURCES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .mode_i     (mode_i),
    .txn_id_i   (txn_id_i),
    .resource_i (resource_i),
    .busy_o     (busy_o),
    .head_o     (head),
    .pop_i      (pop)
  );

  ltdc_back #(.TXNS(TXNS), .RESOURCES(RESOURCES)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .done_o    (done_o),
    .status_o  (status_o),
    .new_txn_o (new_txn_o)
  );

endmodule

@@ rtl/ltdc_checker.sv @@
// ltdc_checker: port-level assertions for the lock table, bound to the top level
// depends on ltdc_pkg and lock_table_with_deadlock_check
module ltdc_checker import ltdc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy_o,
  input logic              done_o,
  input logic [ST_W-1:0]   status_o,
  input logic [ID_W-1:0]   new_txn_o
);

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= ST_NOSLOT))
    else $error("status code out of range");

  a_slot_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (new_txn_o == '0))
    else $error("slot number on a failed beat");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !done_o)
    else $error("result right after reset");

  a_not_busy_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(!rst_ni) || $past(!rst_ni, 2)) |-> !busy_o)
    else $error("queue full too soon after reset");

endmodule

bind lock_table_with_deadlock_check ltdc_checker u_ltdc_checker (.*);
